>>> rtl/stid_pkg.sv
// Package: table sizes, operation and status codes, entry and control types.
`timescale 1ns / 1ps

package stid_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [63:0]        key;
        logic [1:0]         type_code;
        logic               scope_code;
        logic signed [31:0] entry_value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic accept;
        logic insert;
        logic miss;
        logic scan;
        logic shift;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       hit;
        logic       scan_miss;
        logic       shift_done;
        logic       out_free;
    } t_sts;

endpackage

>>> rtl/stid_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface stid_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [63:0]        key;
    logic [1:0]         type_code;
    logic               scope_code;
    logic signed [31:0] entry_value;

    modport source (output valid, mode, key, type_code, scope_code, entry_value,
                    input ready);
    modport sink (input valid, mode, key, type_code, scope_code, entry_value,
                  output ready);
endinterface

interface stid_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [1:0]         found_type;
    logic               found_scope;
    logic signed [31:0] found_value;

    modport source (output valid, status, found_type, found_scope, found_value,
                    input ready);
    modport sink (input valid, status, found_type, found_scope, found_value,
                  output ready);
endinterface

>>> rtl/symbol_table_insert_search_delete.sv
// Top level: linear symbol table with insert, search and delete.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+--------------------------------------------
//  i_req    | in  | valid/ready  | mode, key, type_code, scope_code, entry_value
//  o_rsp    | out | valid/ready  | status, found_type, found_scope, found_value
//
//  One item at a time. Insert and unused mode go from decode straight to the result.
//  Search scans to the match or the end of the table; delete then shifts the later
//  entries down, so scan and shift walk the table once through one read port.
//  Reset (synchronous, active low) empties the table; entries need no clearing.
//  A new item is accepted while a result waits on o_rsp; o_rsp stalls hold it.
`timescale 1ns / 1ps

module symbol_table_insert_search_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stid_req_if.sink    i_req,
    stid_rsp_if.source  o_rsp
);

    stid_pkg::t_cmd cmd;
    stid_pkg::t_sts sts;

    stid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stid_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_req.mode),
        .i_key         (i_req.key),
        .i_type_code   (i_req.type_code),
        .i_scope_code  (i_req.scope_code),
        .i_entry_value (i_req.entry_value),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_found_type  (o_rsp.found_type),
        .o_found_scope (o_rsp.found_scope),
        .o_found_value (o_rsp.found_value)
    );

endmodule

>>> rtl/stid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/stid_dp.sv
// Datapath: item register, entry RAM, scan and shift pointers, result registers.
`timescale 1ns / 1ps

module stid_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stid_pkg::t_cmd        i_cmd,
    output stid_pkg::t_sts        o_sts,
    input  logic [1:0]            i_mode,
    input  logic [63:0]           i_key,
    input  logic [1:0]            i_type_code,
    input  logic                  i_scope_code,
    input  logic signed [31:0]    i_entry_value,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output logic [2:0]            o_status,
    output logic [1:0]            o_found_type,
    output logic                  o_found_scope,
    output logic signed [31:0]    o_found_value
);

    logic [1:0]                  r_mode;
    stid_pkg::t_entry            r_item;
    logic [stid_pkg::CNT_W-1:0]  r_count;
    logic [stid_pkg::CNT_W-1:0]  r_rd_idx;
    logic                        r_cmp_vld;
    logic                        r_sh_vld;
    logic [stid_pkg::IDX_W-1:0]  r_wr_idx;
    logic [2:0]                  r_res_status;
    logic [1:0]                  r_res_type;
    logic                        r_res_scope;
    logic signed [31:0]          r_res_value;
    logic                        r_out_valid;
    logic [2:0]                  r_out_status;
    logic [1:0]                  r_out_type;
    logic                        r_out_scope;
    logic signed [31:0]          r_out_value;

    stid_pkg::t_entry            rd_entry;
    logic [stid_pkg::ENTRY_W-1:0] rd_raw;
    logic [stid_pkg::ENTRY_W-1:0] wr_raw;
    logic                        hit;
    logic                        at_end;
    logic                        full;
    logic                        scan_rd;
    logic                        shift_rd;
    logic                        ram_we;
    logic                        ram_re;
    logic [stid_pkg::IDX_W-1:0]  ram_waddr;
    logic                        shift_done;

    assign rd_entry   = stid_pkg::t_entry'(rd_raw);
    assign hit        = r_cmp_vld && (rd_entry.key == r_item.key);
    assign at_end     = (r_rd_idx == r_count);
    assign full       = (r_count == stid_pkg::CNT_W'(stid_pkg::TABLE_DEPTH));
    assign scan_rd    = i_cmd.scan && !hit && !at_end;
    assign shift_rd   = i_cmd.shift && !at_end;
    assign shift_done = at_end && !r_sh_vld;
    assign ram_re     = scan_rd || shift_rd;
    assign ram_we     = (i_cmd.insert && !full) || (i_cmd.shift && r_sh_vld);
    assign ram_waddr  = i_cmd.insert ? r_count[stid_pkg::IDX_W-1:0] : r_wr_idx;
    assign wr_raw     = i_cmd.insert ? r_item : rd_entry;

    stid_ram #(
        .WIDTH (stid_pkg::ENTRY_W),
        .DEPTH (stid_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_raw),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[stid_pkg::IDX_W-1:0]),
        .o_rdata (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_sh_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.insert && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= scan_rd;
                if (hit) begin
                    r_sh_vld <= 1'b0;
                end
            end
            if (i_cmd.shift) begin
                r_sh_vld <= shift_rd;
                if (shift_done) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode                 <= i_mode;
            r_item.key             <= i_key;
            r_item.type_code       <= i_type_code;
            r_item.scope_code      <= i_scope_code;
            r_item.entry_value     <= i_entry_value;
            r_rd_idx               <= '0;
        end
        if (i_cmd.insert) begin
            r_res_status <= full ? stid_pkg::ST_FULL : stid_pkg::ST_INSERTED;
            r_res_type   <= '0;
            r_res_scope  <= 1'b0;
            r_res_value  <= '0;
        end
        if (i_cmd.miss || (i_cmd.scan && !hit && at_end)) begin
            r_res_status <= stid_pkg::ST_NOT_FOUND;
            r_res_type   <= '0;
            r_res_scope  <= 1'b0;
            r_res_value  <= '0;
        end
        if (i_cmd.scan) begin
            if (scan_rd) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (hit) begin
                r_res_status <= (r_mode == stid_pkg::MODE_DELETE) ?
                                stid_pkg::ST_DELETED : stid_pkg::ST_FOUND;
                r_res_type   <= rd_entry.type_code;
                r_res_scope  <= rd_entry.scope_code;
                r_res_value  <= rd_entry.entry_value;
                // rd_idx already points one past the match
                r_wr_idx     <= r_rd_idx[stid_pkg::IDX_W-1:0] - 1'b1;
            end
        end
        if (i_cmd.shift) begin
            if (shift_rd) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_sh_vld) begin
                r_wr_idx <= r_wr_idx + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_type   <= r_res_type;
            r_out_scope  <= r_res_scope;
            r_out_value  <= r_res_value;
        end
    end

    assign o_sts.mode       = r_mode;
    assign o_sts.hit        = hit;
    assign o_sts.scan_miss  = !hit && at_end;
    assign o_sts.shift_done = shift_done;
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_type  = r_out_type;
    assign o_found_scope = r_out_scope;
    assign o_found_value = r_out_value;

endmodule

>>> rtl/stid_ctrl.sv
// Controller: sequences decode, key scan, delete shift and result hand-off.
`timescale 1ns / 1ps

module stid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  stid_pkg::t_sts i_sts,
    output stid_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.mode)
                    stid_pkg::MODE_INSERT: begin
                        o_cmd.insert = 1'b1;
                        n_state      = S_DONE;
                    end
                    stid_pkg::MODE_SEARCH, stid_pkg::MODE_DELETE: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        o_cmd.miss = 1'b1;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = (i_sts.mode == stid_pkg::MODE_DELETE) ? S_SHIFT : S_DONE;
                end else if (i_sts.scan_miss) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/stid_chk.sv
// Checker on the top-level ports, bound into the symbol table.
`timescale 1ns / 1ps

module stid_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_status,
    input logic [1:0]  i_found_type,
    input logic        i_found_scope,
    input logic [31:0] i_found_value
);

    // a result held back by the sink stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_status <= stid_pkg::ST_FULL)
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == stid_pkg::ST_INSERTED ||
                        i_status == stid_pkg::ST_NOT_FOUND ||
                        i_status == stid_pkg::ST_FULL)
        |-> i_found_type == 2'd0 && !i_found_scope && i_found_value == 32'd0)
        else $error("found fields not zero without a match");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

endmodule

bind symbol_table_insert_search_delete stid_chk u_stid_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_found_type  (o_rsp.found_type),
    .i_found_scope (o_rsp.found_scope),
    .i_found_value (o_rsp.found_value)
);

>>> tb/testbench.sv
// Testbench: random and directed insert/search/delete traffic checked against a table mirror.
`timescale 1ns / 1ps

import stid_pkg::*;

typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         ftype;
    logic               fscope;
    logic signed [31:0] fvalue;
} answer_t;

class symbol_table_mirror;
    t_entry  entries[$];
    answer_t awaited_answers[$];
    int      fails;

    function new();
        fails = 0;
    endfunction

    // Update the mirrored table for one accepted item and queue its answer.
    function void apply_request(logic [1:0] mode, logic [63:0] key, logic [1:0] ty,
                                logic sc, logic signed [31:0] val);
        answer_t a;
        t_entry  e;
        int      hit;
        a   = '0;
        hit = -1;
        if (mode == MODE_INSERT) begin
            if (entries.size() >= TABLE_DEPTH) begin
                a.status = ST_FULL;
            end else begin
                e.key         = key;
                e.type_code   = ty;
                e.scope_code  = sc;
                e.entry_value = val;
                entries.push_back(e);
                a.status = ST_INSERTED;
            end
        end else begin
            if (mode != MODE_UNUSED) begin
                foreach (entries[i]) begin
                    if (hit < 0 && entries[i].key == key) hit = i;
                end
            end
            if (hit < 0) begin
                a.status = ST_NOT_FOUND;
            end else begin
                a.status = (mode == MODE_SEARCH) ? ST_FOUND : ST_DELETED;
                a.ftype  = entries[hit].type_code;
                a.fscope = entries[hit].scope_code;
                a.fvalue = entries[hit].entry_value;
                if (mode == MODE_DELETE) entries.delete(hit);
            end
        end
        awaited_answers.push_back(a);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            fails++;
        end
    endfunction

    function void match_answer(logic [2:0] status, logic [1:0] ftype, logic fscope,
                               logic signed [31:0] fvalue);
        answer_t want;
        if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual status %h value %h",
                     $time, status, fvalue);
            fails++;
            return;
        end
        want = awaited_answers.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("found_type", 32'(want.ftype), 32'(ftype));
        compare_field("found_scope", 32'(want.fscope), 32'(fscope));
        compare_field("found_value", want.fvalue, fvalue);
    endfunction
endclass

module testbench;

    logic i_clk;
    logic i_rst_n;

    stid_req_if req_if();
    stid_rsp_if rsp_if();

    symbol_table_mirror mirror = new();

    logic [63:0] key_pool [16];
    bit          quiet = 1'b0;
    int          num_sent = 0;

    symbol_table_insert_search_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic send_request(logic [1:0] mode, logic [63:0] key, logic [1:0] ty,
                                logic sc, logic signed [31:0] val);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2 * TABLE_DEPTH + 8)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.key         <= key;
        req_if.type_code   <= ty;
        req_if.scope_code  <= sc;
        req_if.entry_value <= val;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        mirror.apply_request(mode, key, ty, sc, val);
        num_sent++;
    endtask

    task automatic settle_responses();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (mirror.awaited_answers.size() != 0);
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && mirror.entries.size() > 0)
            return mirror.entries[$urandom_range(0, mirror.entries.size() - 1)].key;
        if (r < 85) return key_pool[$urandom_range(0, 15)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [1:0] pick_mode(int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) return MODE_INSERT;
        r = $urandom_range(0, 99);
        if (r < 45) return MODE_SEARCH;
        if (r < 92) return MODE_DELETE;
        return MODE_UNUSED;
    endfunction

    task automatic run_phase(int ins_pct, int n);
        repeat (n) begin
            send_request(pick_mode(ins_pct), pick_key(), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    // Response side: random back-pressure and checking.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                mirror.match_answer(rsp_if.status, rsp_if.found_type,
                                    rsp_if.found_scope, rsp_if.found_value);
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_INSERT;
        req_if.key         <= '0;
        req_if.type_code   <= '0;
        req_if.scope_code  <= 1'b0;
        req_if.entry_value <= '0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, duplicates, unused mode, deletes at each end
        send_request(MODE_SEARCH, 64'h1, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_DELETE, 64'h1, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_UNUSED, '0, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_INSERT, '0, 2'd0, 1'b0, 32'sh8000_0000);
        send_request(MODE_INSERT, '1, 2'd3, 1'b1, 32'sh7fff_ffff);
        send_request(MODE_INSERT, '1, 2'd1, 1'b0, -32'sd1);
        send_request(MODE_INSERT, 64'h41, 2'd2, 1'b1, 32'sd0);
        send_request(MODE_SEARCH, '1, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_SEARCH, '0, 2'd3, 1'b1, '1);
        send_request(MODE_SEARCH, 64'h41, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_SEARCH, 64'h1234, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_UNUSED, '0, 2'd3, 1'b1, '1);
        send_request(MODE_DELETE, '1, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_SEARCH, '1, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_DELETE, '0, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_DELETE, 64'h41, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_DELETE, 64'h41, 2'd0, 1'b0, 32'sd0);
        send_request(MODE_DELETE, '1, 2'd0, 1'b0, 32'sd0);

        // fill to the top, then overflow
        while (mirror.entries.size() < TABLE_DEPTH)
            send_request(MODE_INSERT, pick_key(), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), $urandom);
        run_phase(100, 3);
        run_phase(40, 30);
        settle_responses();
        run_phase(8, 90);
        quiet = 1'b1;
        run_phase(55, 100);
        quiet = 1'b0;
        while (num_sent < 530) begin
            run_phase($urandom_range(10, 90), $urandom_range(20, 60));
            if ($urandom_range(0, 3) == 0) settle_responses();
        end

        settle_responses();
        repeat (2 * TABLE_DEPTH + 8) @(posedge i_clk);
        if (mirror.fails == 0 && mirror.awaited_answers.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> symbol_table_insert_search_delete.f
rtl/stid_pkg.sv
rtl/stid_if.sv
rtl/stid_ram.sv
rtl/stid_dp.sv
rtl/stid_ctrl.sv
rtl/symbol_table_insert_search_delete.sv
rtl/stid_chk.sv
tb/testbench.sv
